// ----- rtl/core/aks_pkg.sv -----
// Package for the ascending key sorter: widths, status codes, IEEE order key.
// No dependencies.
package aks_pkg;
    localparam int KEY_W        = 64;
    localparam int CNT_W        = 9;
    localparam int CAPACITY_DEF = 256;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // command broadcast to every cell
    typedef struct packed {
        logic             load;
        logic             drain;
        logic [KEY_W-1:0] key;
    } aks_cmd_t;

    // map IEEE bit pattern to an unsigned total-order key
    function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] r;
        if (bits[KEY_W-1]) begin
            r = ~bits;
        end else begin
            r = bits | {1'b1, {(KEY_W-1){1'b0}}};
        end
        return r;
    endfunction
endpackage

// ----- rtl/core/aks_cell.sv -----
// One cell of the sorted chain: holds a key and a valid flag.
// Depends on aks_pkg.
module aks_cell
    import aks_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  aks_cmd_t         cmd,
    input  logic             left_valid,
    input  logic             left_gt,     // left neighbor key > new key
    input  logic [KEY_W-1:0] left_key,
    input  logic             right_valid,
    input  logic [KEY_W-1:0] right_key,
    output logic             valid,
    output logic             gt,
    output logic [KEY_W-1:0] key
);
    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;

    assign gt    = valid_reg && (order_key(key_reg) > order_key(cmd.key));
    assign valid = valid_reg;
    assign key   = key_reg;

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.load) begin
            // stable insert: shift if left moves, else new key if gt or first free
            if (left_valid && left_gt) begin
                key_next   = left_key;
                valid_next = 1'b1;
            end else if (gt || (!valid_reg && left_valid)) begin
                key_next   = cmd.key;
                valid_next = 1'b1;
            end
        end else if (cmd.drain) begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end
endmodule

// ----- rtl/core/ascending_key_sorter_top.sv -----
// Top level of the ascending key sorter: cell chain, count and output register.
// Depends on aks_pkg, aks_cell.
//
// Keys sit in a chain of CAPACITY cells kept in ascending IEEE order; a load
// is inserted by every cell comparing against the new key and shifting
// right, a drain shifts the chain left. One result follows per item; a new
// item is taken while the previous result waits as long as the output
// register is free or is being read. Loading into a full chain drops the
// key with status 1; draining an empty chain returns status 2. Equal keys
// drain in load order.
module ascending_key_sorter_top
    import aks_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [KEY_W-1:0] s_key_bits,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_sorted_key,
    output logic [1:0]       m_status,
    output logic [CNT_W-1:0] m_remaining,
    output logic             m_last_key
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             ovalid_reg;
    logic [KEY_W-1:0] okey_reg;
    logic [1:0]       ostat_reg;
    logic [CNT_W-1:0] orem_reg;
    logic             olast_reg;

    logic             take, full, empty;
    aks_cmd_t         cmd;
    logic [CAPACITY-1:0] v, g;
    logic [KEY_W-1:0]    k [CAPACITY];

    assign s_ready = !ovalid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    assign cmd.load  = take && (s_kind == KIND_LOAD) && !full;
    assign cmd.drain = take && (s_kind == KIND_DRAIN) && !empty;
    assign cmd.key   = s_key_bits;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic             lv, lg, rv;
            logic [KEY_W-1:0] lk, rk;
            if (i == 0) begin : g_first
                // virtual head: treat as valid and not greater
                assign lv = 1'b1;
                assign lg = 1'b0;
                assign lk = '0;
            end else begin : g_mid
                assign lv = v[i-1];
                assign lg = g[i-1];
                assign lk = k[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign rv = 1'b0;
                assign rk = '0;
            end else begin : g_nxt
                assign rv = v[i+1];
                assign rk = k[i+1];
            end
            aks_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .left_valid  (lv),
                .left_gt     (lg),
                .left_key    (lk),
                .right_valid (rv),
                .right_key   (rk),
                .valid       (v[i]),
                .gt          (g[i]),
                .key         (k[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.load) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.drain) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (take) begin
                ovalid_reg <= 1'b1;
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
        if (take) begin
            okey_reg  <= cmd.drain ? k[0] : '0;
            ostat_reg <= ((s_kind == KIND_LOAD) && full)   ? STATUS_FULL :
                         ((s_kind == KIND_DRAIN) && empty) ? STATUS_EMPTY : STATUS_OK;
            orem_reg  <= CNT_W'(count_next);
            olast_reg <= cmd.drain && (count_reg == CW'(1));
        end
    end

    assign m_valid      = ovalid_reg;
    assign m_sorted_key = okey_reg;
    assign m_status     = ostat_reg;
    assign m_remaining  = orem_reg;
    assign m_last_key   = olast_reg;
endmodule

// ----- verif/testbench.sv -----
// Testbench for the ascending key sorter: queue-fed driver, result monitor,
// and an in-bench ordered-store model of the sort. Depends on aks_pkg and the top.
module testbench;
    import aks_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] bits;
    } key_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [1:0]       status;
        logic [CNT_W-1:0] remaining;
        logic             last;
    } sort_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_kind = 1'b0;
    logic [KEY_W-1:0] s_key_bits = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [KEY_W-1:0] m_sorted_key;
    logic [1:0]       m_status;
    logic [CNT_W-1:0] m_remaining;
    logic             m_last_key;

    ascending_key_sorter_top u_top (.*);

    always #4 aclk = ~aclk;

    key_item_t    pending_items[$];
    sort_result_t expected_results[$];
    logic [KEY_W-1:0] sorted_keys[$];  // model store, ascending
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  stim_done = 1'b0;
    bit  hold_send = 1'b0;
    int  send_wait = 0;
    int  recv_wait = 0;

    function automatic logic [KEY_W-1:0] ieee_rank(logic [KEY_W-1:0] b);
        return b[KEY_W-1] ? ~b : (b | {1'b1, {(KEY_W-1){1'b0}}});
    endfunction

    function automatic sort_result_t predict_sort(key_item_t it);
        sort_result_t r;
        int pos;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            if (sorted_keys.size() >= CAP) begin
                r.status = STATUS_FULL;
            end else begin
                pos = sorted_keys.size();
                while (pos > 0 && ieee_rank(sorted_keys[pos-1]) > ieee_rank(it.bits))
                    pos--;
                sorted_keys.insert(pos, it.bits);
                r.status = STATUS_OK;
            end
        end else begin
            if (sorted_keys.size() == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.key = sorted_keys.pop_front();
                r.status = STATUS_OK;
                r.last = (sorted_keys.size() == 0);
            end
        end
        r.remaining = CNT_W'(sorted_keys.size());
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold transaction
        end else if (send_wait > 0) begin
            s_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (pending_items.size() > 0 && !hold_send) begin
            key_item_t it;
            it = pending_items.pop_front();
            expected_results.push_back(predict_sort(it));
            s_valid <= 1'b1;
            s_kind <= it.kind;
            s_key_bits <= it.bits;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sort_result_t e;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result key=%h status=%0d",
                                 m_sorted_key, m_status);
                end else begin
                    e = expected_results.pop_front();
                    if (e.key !== m_sorted_key || e.status !== m_status ||
                        e.remaining !== m_remaining || e.last !== m_last_key) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp key=%h st=%0d rem=%0d last=%0d",
                                      " got key=%h st=%0d rem=%0d last=%0d"},
                                     e.key, e.status, e.remaining, e.last, m_sorted_key,
                                     m_status, m_remaining, m_last_key);
                    end
                end
            end
            if (recv_wait > 0 && !(m_valid && m_ready)) begin
                m_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else if (m_valid && m_ready) begin
                recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_item(logic k, logic [KEY_W-1:0] b);
        key_item_t it;
        it.kind = k;
        it.bits = b;
        pending_items.push_back(it);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: b = {1'($urandom_range(0, 1)), 63'd0};                  // signed zero
            1: b = {1'($urandom_range(0, 1)), 11'h7ff, 52'd0};         // infinity
            2: b = {1'($urandom_range(0, 1)), 11'd0, 44'd0, 8'($urandom)}; // tiny
            3: b = {1'($urandom_range(0, 1)), 11'h3ff, 52'($urandom_range(0, 3))};
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        int burst;
        logic [KEY_W-1:0] dup;
        // directed: empty drain, signed zeros, infinities, extremes, equal keys
        add_item(KIND_DRAIN, '0);
        add_item(KIND_LOAD, 64'h0000_0000_0000_0000);
        add_item(KIND_LOAD, 64'h8000_0000_0000_0000);
        add_item(KIND_LOAD, 64'h7ff0_0000_0000_0000);
        add_item(KIND_LOAD, 64'hfff0_0000_0000_0000);
        add_item(KIND_LOAD, 64'h3ff0_0000_0000_0000);
        add_item(KIND_LOAD, 64'h3ff0_0000_0000_0000);
        add_item(KIND_LOAD, 64'hbff0_0000_0000_0000);
        add_item(KIND_LOAD, 64'hffff_ffff_ffff_ffff);
        add_item(KIND_LOAD, 64'h7fff_ffff_ffff_ffff);
        add_item(KIND_LOAD, 64'h0000_0000_0000_0001);
        add_item(KIND_LOAD, 64'h8000_0000_0000_0001);
        for (int i = 0; i < 12; i++) add_item(KIND_DRAIN, '0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // fill to capacity and past it, drain it all out
        for (int i = 0; i < CAP + 3; i++) add_item(KIND_LOAD, rand_key());
        for (int i = 0; i < CAP + 2; i++) add_item(KIND_DRAIN, {$urandom, $urandom});
        // wait for everything to drain through before going on
        while (pending_items.size() > 0 || expected_results.size() > 0 || s_valid) begin
            @(posedge aclk);
            if (cycle_count > MAX_CYCLE) begin
                $display("Test completed with failures");
                $finish;
            end
        end
        hold_send = 1'b1;
        repeat (20) @(posedge aclk);
        hold_send = 1'b0;

        // random bursts of loads then mostly drains, duplicates mixed in
        while (pending_items.size() < 950) begin
            burst = $urandom_range(1, 40);
            dup = rand_key();
            for (int i = 0; i < burst; i++)
                add_item(KIND_LOAD, ($urandom_range(0, 4) == 0) ? dup : rand_key());
            burst = $urandom_range(1, 45);
            for (int i = 0; i < burst; i++)
                add_item(($urandom_range(0, 5) != 0) ? KIND_DRAIN : KIND_LOAD,
                         {$urandom, $urandom});
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending_items.size() > 0 || expected_results.size() > 0) begin
            @(posedge aclk);
            if (cycle_count > MAX_CYCLE) begin
                $display("Test completed with failures");
                $finish;
            end
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
